// File: hw/rtl/bda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bda_pkg;

   localparam int VALUE_W   = 16;
   localparam int CHAR_W    = 6;
   localparam int NUM_CELLS = 5;
   localparam int BCD_W     = 4;
   localparam int BIT_CNT_W = $clog2(VALUE_W);
   localparam int REM_W     = $clog2(NUM_CELLS + 1);

   localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
   localparam logic [BCD_W-1:0]  DABBLE_MIN = BCD_W'(5);
   localparam logic [BCD_W-1:0]  DABBLE_ADD = BCD_W'(3);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic rotate;
   } cell_ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/bda_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bda_cell
// One BCD digit: cleared in clear mode, add-3 correction and shift in dabble
// mode, nibble hand-over in rotate mode.
// ----------------------------------------------------------------------------
module bda_cell
   import bda_pkg::*;
(
   input  wire logic              clock,
   input  wire cell_ctl_type      ctl,
   input  wire logic              bit_in,
   input  wire logic [BCD_W-1:0]  nib_in,
   output logic                   carry_out,
   output logic [BCD_W-1:0]       digit
);

   logic [BCD_W-1:0] digit_ff;
   logic [BCD_W-1:0] digit_in;
   logic [BCD_W-1:0] adj;

   always_comb begin
      adj = (digit_ff >= DABBLE_MIN) ? digit_ff + DABBLE_ADD : digit_ff;
      carry_out = adj[BCD_W-1];
      digit_in = digit_ff;
      if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.dabble) begin
         digit_in = {adj[BCD_W-2:0], bit_in};
      end else if (ctl.rotate) begin
         digit_in = nib_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule
`default_nettype wire

// File: hw/rtl/bda_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bda_chain
// Row of BCD cells, least significant first; carries and nibbles move
// toward the most significant cell.
// ----------------------------------------------------------------------------
module bda_chain
   import bda_pkg::*;
(
   input  wire logic             clock,
   input  wire cell_ctl_type     ctl,
   input  wire logic             serial_in,
   output logic [BCD_W-1:0]      top_digit
);

   logic [NUM_CELLS-1:0]            carry;
   logic [NUM_CELLS-1:0][BCD_W-1:0] digit;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      logic             bit_in;
      logic [BCD_W-1:0] nib_in;
      if (i == 0) begin : g_first
         assign bit_in = serial_in;
         assign nib_in = '0;
      end else begin : g_rest
         assign bit_in = carry[i-1];
         assign nib_in = digit[i-1];
      end
      bda_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .bit_in    (bit_in),
         .nib_in    (nib_in),
         .carry_out (carry[i]),
         .digit     (digit[i])
      );
   end

   assign top_digit = digit[NUM_CELLS-1];

endmodule
`default_nettype wire

// File: hw/rtl/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned 16-bit value to ASCII decimal digits, most significant
// first, leading zeros suppressed.
// ----------------------------------------------------------------------------
// One value is taken at a time. A row of five BCD cells runs the shift and
// add-3 conversion over every bit of the value, then rotates its digits out
// of the top cell, one per cycle unless a printed digit waits on rsp_stall,
// skipping leading zeros; each printed digit is one rsp_ beat, the final one
// with rsp_last_digit set. The last beat may still wait in the output
// register while the next value is taken.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
   import bda_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [VALUE_W-1:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [CHAR_W-1:0]       rsp_digit_char,
   output logic                    rsp_last_digit
);

   state_type             state_ff, state_in;
   logic [VALUE_W-1:0]    shift_ff, shift_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic                  started_ff, started_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]     out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;

   cell_ctl_type          cell_ctl;
   logic [BCD_W-1:0]      top_digit;
   logic                  accept;
   logic                  out_free;
   logic                  skip;
   logic                  advance;
   logic                  emit;

   bda_chain u_chain (
      .clock     (clock),
      .ctl       (cell_ctl),
      .serial_in (shift_ff[VALUE_W-1]),
      .top_digit (top_digit)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign skip     = (top_digit == '0) && !started_ff && (rem_ff != REM_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (advance && rem_ff == REM_W'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall       = 1'b1;
      cell_ctl        = '0;
      advance         = 1'b0;
      emit            = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall      = 1'b0;
            cell_ctl.clear = accept;
         end
         ST_CONV: begin
            cell_ctl.dabble = 1'b1;
         end
         ST_EMIT: begin
            advance         = skip || out_free;
            emit            = !skip && out_free;
            cell_ctl.rotate = advance;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      shift_in     = shift_ff;
      bit_cnt_in   = bit_cnt_ff;
      rem_in       = rem_ff;
      started_in   = started_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (accept) begin
         shift_in   = req_value;
         bit_cnt_in = '0;
         rem_in     = REM_W'(NUM_CELLS);
         started_in = 1'b0;
      end
      if (cell_ctl.dabble) begin
         shift_in   = {shift_ff[VALUE_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
      end
      if (advance) begin
         rem_in = rem_ff - REM_W'(1);
      end
      if (emit) begin
         started_in   = 1'b1;
         out_valid_in = 1'b1;
         out_char_in  = ASCII_ZERO + CHAR_W'(top_digit);
         out_last_in  = (rem_ff == REM_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      shift_ff    <= shift_in;
      bit_cnt_ff  <= bit_cnt_in;
      rem_ff      <= rem_in;
      started_ff  <= started_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last_digit = out_last_ff;

endmodule
`default_nettype wire

// File: hw/rtl/bda_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bda_checker
// Port-level checks for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
module bda_checker
   import bda_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [CHAR_W-1:0]  rsp_digit_char,
   input  wire logic               rsp_last_digit
);

   // hold a stalled beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit_char)
                                 && $stable(rsp_last_digit))
      else $error("stalled rsp beat changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> $stable(req_value))
      else $error("stalled req beat changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req taken again without conversion");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_char >= CHAR_W'(48) && rsp_digit_char <= CHAR_W'(57))
      else $error("rsp character not a decimal digit");

   a_open_number_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_digit |-> req_stall)
      else $error("req open while a number is unfinished");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_value      (req_value),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_digit_char (rsp_digit_char),
   .rsp_last_digit (rsp_last_digit)
);
`default_nettype wire
